// ===== hdl/psq_pkg.sv =====
// Shared types and constants for the priority sleep queue.
package psq_pkg;

  localparam int DEPTH_DEF = 32;

  localparam int FUNC_W = 2;
  localparam int TID_W  = 16;
  localparam int PRIO_W = 8;
  localparam int CHAN_W = 32;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 2'd0,
    FN_REMOVE   = 2'd1,
    FN_WAKE_ONE = 2'd2,
    FN_WAKE_ALL = 2'd3
  } psq_func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } psq_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EVAL = 2'd2,
    S_DONE = 2'd3
  } psq_state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [PRIO_W-1:0] prio;
    logic [TID_W-1:0]  thread;
  } psq_entry_t;

endpackage

// ===== hdl/psq_slot_ram.sv =====
// Slot storage: one write port and one registered read port.
module psq_slot_ram
  import psq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  psq_entry_t               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output psq_entry_t               rd_data
);

  psq_entry_t mem_r [DEPTH];
  psq_entry_t rd_data_r;

  // Write one slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read one slot, hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/priority_sleep_queue.sv =====
// Priority-ordered wait queue: insert, remove, wake-one and wake-all.
//
// Input channel (in_*): one request per handshake, carrying func, thread id,
// priority and channel key. The block takes one request at a time; in_tready
// is high only while no request is in progress.
// Result channel (out_*): status and thread id in out_tdata, out_tlast high
// on the final result of a request. Wake-all gives one result per woken entry
// (one not-found result if none); every other request gives exactly one result.
// Entries live in a single-port-write, single-port-read slot memory and are
// walked one slot at a time by a small sequencer: each slot is read, then
// evaluated and written back; a result stall can hold a wake-all walk.
// An insert into a full queue skips the walk. The final result turns valid in
// the same cycle that in_tready rises again.
// Reset empties the queue at once; slot contents are not cleared, since only
// slots below the occupancy are ever read. No clearing pass is needed.
// When the receiver stalls, the result register holds; a wake-all scan
// pauses on its next hit until the held result is taken.
module priority_sleep_queue
  import psq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] func, [17:2] thread_id, [25:18] priority_req, [57:26] channel
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [17:2] out_thread
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  psq_state_t  state_r, state_nxt;
  psq_func_t   func_r, func_nxt;
  logic [TID_W-1:0]  tid_r, tid_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic        full_r, full_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] rd_i_r, rd_i_nxt;
  logic [CW-1:0] wr_i_r, wr_i_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [TID_W-1:0] pend_thread_r, pend_thread_nxt;
  logic        out_valid_r, out_valid_nxt;
  psq_status_t out_status_r, out_status_nxt;
  logic [TID_W-1:0] out_thread_r, out_thread_nxt;
  logic        out_last_r, out_last_nxt;

  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  psq_entry_t  mem_wdata;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;
  psq_entry_t  rd;

  logic        in_accept;
  logic        out_free;
  logic        is_insert;
  logic        scan_end;
  logic        match;
  logic        hit;
  logic        hit_stall;
  logic        shift;
  logic        q_full;
  logic [CW-1:0] rd_i_dec;

  psq_slot_ram #(.DEPTH(DEPTH)) u_slots (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd)
  );

  // Handshake and scan decisions
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign is_insert = (func_r == FN_INSERT);
  assign scan_end  = (rd_i_r == occ_r);
  assign q_full    = (occ_r == CW'(DEPTH));
  assign rd_i_dec  = rd_i_r - CW'(1);
  assign match     = (func_r == FN_REMOVE) ? (rd.thread == tid_r) : (rd.chan == chan_r);
  assign hit       = match && ((func_r == FN_WAKE_ALL) || !pend_valid_r);
  assign hit_stall = hit && pend_valid_r && !out_free;
  assign shift     = (rd_i_r != '0) && (rd.prio < prio_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if ((psq_func_t'(in_tdata[1:0]) == FN_INSERT) && q_full) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (is_insert || !scan_end) begin
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EVAL: begin
        if (is_insert) begin
          state_nxt = shift ? S_READ : S_DONE;
        end else begin
          state_nxt = hit_stall ? S_EVAL : S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    func_nxt        = func_r;
    tid_nxt         = tid_r;
    prio_nxt        = prio_r;
    chan_nxt        = chan_r;
    full_nxt        = full_r;
    occ_nxt         = occ_r;
    rd_i_nxt        = rd_i_r;
    wr_i_nxt        = wr_i_r;
    pend_valid_nxt  = pend_valid_r;
    pend_thread_nxt = pend_thread_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_thread_nxt  = out_thread_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_waddr       = wr_i_r[AW-1:0];
    mem_wdata       = rd;
    mem_re          = 1'b0;
    mem_raddr       = rd_i_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        // Latch the request and set up the walk
        if (in_accept) begin
          func_nxt       = psq_func_t'(in_tdata[1:0]);
          tid_nxt        = in_tdata[17:2];
          prio_nxt       = in_tdata[25:18];
          chan_nxt       = in_tdata[57:26];
          full_nxt       = (psq_func_t'(in_tdata[1:0]) == FN_INSERT) && q_full;
          rd_i_nxt       = (psq_func_t'(in_tdata[1:0]) == FN_INSERT) ? occ_r : '0;
          wr_i_nxt       = '0;
          pend_valid_nxt = 1'b0;
        end
      end
      S_READ: begin
        if (is_insert) begin
          // Insert walks from the tail toward the head
          mem_re    = (rd_i_r != '0);
          mem_raddr = rd_i_dec[AW-1:0];
        end else if (!scan_end) begin
          mem_re = 1'b1;
        end else begin
          occ_nxt = wr_i_r;
        end
      end
      S_EVAL: begin
        if (is_insert) begin
          // Move a lower-priority entry down one slot, or drop the new one in
          mem_we    = 1'b1;
          mem_waddr = rd_i_r[AW-1:0];
          if (shift) begin
            mem_wdata = rd;
            rd_i_nxt  = rd_i_dec;
          end else begin
            mem_wdata.chan   = chan_r;
            mem_wdata.prio   = prio_r;
            mem_wdata.thread = tid_r;
            occ_nxt          = occ_r + CW'(1);
          end
        end else if (hit) begin
          // Take the entry out; push the older hit to the result register
          if (!hit_stall) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_thread_nxt = pend_thread_r;
              out_last_nxt   = 1'b0;
            end
            pend_valid_nxt  = 1'b1;
            pend_thread_nxt = rd.thread;
            rd_i_nxt        = rd_i_r + CW'(1);
          end
        end else begin
          // Keep the entry, compacting toward the head
          mem_we   = 1'b1;
          wr_i_nxt = wr_i_r + CW'(1);
          rd_i_nxt = rd_i_r + CW'(1);
        end
      end
      S_DONE: begin
        // Deliver the final result of the request
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (full_r) begin
            out_status_nxt = ST_FULL;
            out_thread_nxt = '0;
          end else if (is_insert) begin
            out_status_nxt = ST_OK;
            out_thread_nxt = tid_r;
          end else if (pend_valid_r) begin
            out_status_nxt = ST_OK;
            out_thread_nxt = pend_thread_r;
          end else begin
            out_status_nxt = ST_NOT_FOUND;
            out_thread_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    tid_r         <= tid_nxt;
    prio_r        <= prio_nxt;
    chan_r        <= chan_nxt;
    full_r        <= full_nxt;
    rd_i_r        <= rd_i_nxt;
    wr_i_r        <= wr_i_nxt;
    pend_thread_r <= pend_thread_nxt;
    out_status_r  <= out_status_nxt;
    out_thread_r  <= out_thread_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STAT_W - TID_W){1'b0}}, out_thread_r, out_status_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // Occupancy never exceeds the slot count
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  // Compaction write pointer never passes the read pointer
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_EVAL) && !is_insert |-> wr_i_r <= rd_i_r)
    else $error("write pointer ahead of read pointer");

  // A rejected insert only happens on a full queue
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_status_r == ST_FULL |-> occ_r == CW'(DEPTH))
    else $error("full status with room left");

  // No held hit survives into idle
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("pending result left over in idle");

  // A non-final result only comes from a wake-all
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> func_r == FN_WAKE_ALL)
    else $error("non-final result outside wake-all");
`endif

endmodule
